// ===== design/tsg_pkg.sv =====
// tsg_pkg: shared constants, codes and coefficient tables of the trajectory
// setpoint generator. Used by tsg_mul, tsg_angle and trajectory_setpoint_generator.
// Depends on nothing.
package tsg_pkg;

    localparam int FRAC     = 16;   // fraction bits of all setpoint values
    localparam int CORDIC_Q = 30;   // fraction bits of sine and cosine
    localparam int CFG_IDX_W = 8;

    // path selector codes
    localparam logic [1:0] MODE_VERTICAL = 2'd0;
    localparam logic [1:0] MODE_CIRCLE   = 2'd1;
    localparam logic [1:0] MODE_SIDEWAYS = 2'd2;
    localparam logic [1:0] MODE_HOLD     = 2'd3;

    // register indexes
    localparam logic [CFG_IDX_W-1:0] REG_RADIUS       = 8'd0;
    localparam logic [CFG_IDX_W-1:0] REG_ANGULAR_RATE = 8'd1;
    localparam logic [CFG_IDX_W-1:0] REG_TIME_LIMIT   = 8'd2;
    localparam logic [CFG_IDX_W-1:0] REG_HOME_X       = 8'd3;
    localparam logic [CFG_IDX_W-1:0] REG_HOME_Y       = 8'd4;
    localparam logic [CFG_IDX_W-1:0] REG_HOME_Z       = 8'd5;

    // sequencer steps of the polynomial paths
    localparam logic [2:0] OP_T2 = 3'd0;
    localparam logic [2:0] OP_T3 = 3'd1;
    localparam logic [2:0] OP_P3 = 3'd2;
    localparam logic [2:0] OP_P2 = 3'd3;
    localparam logic [2:0] OP_P1 = 3'd4;
    localparam logic [2:0] OP_V2 = 3'd5;
    localparam logic [2:0] OP_V1 = 3'd6;
    localparam logic [2:0] OP_A1 = 3'd7;

    // sequencer steps of the circle path
    localparam logic [2:0] OP_WT = 3'd0;
    localparam logic [2:0] OP_RC = 3'd1;
    localparam logic [2:0] OP_RS = 3'd2;
    localparam logic [2:0] OP_VX = 3'd3;
    localparam logic [2:0] OP_VY = 3'd4;
    localparam logic [2:0] OP_AX = 3'd5;
    localparam logic [2:0] OP_AY = 3'd6;

    // k/25 coefficients rounded to nearest
    localparam longint CQ_1  = ((longint'(1)  <<< FRAC) * 2 + 25) / 50;
    localparam longint CQ_3  = ((longint'(3)  <<< FRAC) * 2 + 25) / 50;
    localparam longint CQ_6  = ((longint'(6)  <<< FRAC) * 2 + 25) / 50;
    localparam longint CQ_9  = ((longint'(9)  <<< FRAC) * 2 + 25) / 50;
    localparam longint CQ_18 = ((longint'(18) <<< FRAC) * 2 + 25) / 50;
    localparam longint CQ_27 = ((longint'(27) <<< FRAC) * 2 + 25) / 50;

    // 2*pi at 60 fraction bits, reduced copies
    localparam longint TWO_PI_Q60 = 64'h6487ED5110B4611A;
    localparam int     RED_SH     = 60 - 2 * FRAC;
    localparam longint TP_RED     = (TWO_PI_Q60 + (longint'(1) <<< (RED_SH - 1))) >>> RED_SH;
    localparam int     Z_SH       = 2 * FRAC - CORDIC_Q;
    localparam longint TP30       = (TWO_PI_Q60 + (longint'(1) <<< 29)) >>> 30;
    localparam longint PI30       = TP30 / 2;
    localparam longint HP30       = TP30 / 4;
    localparam int     RED_TOP    = 28;   // |w*t| < 2^63 and TP_RED > 2^34
    localparam longint KINF_Q30   = 652032874;

    function automatic logic signed [31:0] atan_q30(input logic [5:0] i);
        logic signed [31:0] v;
        case (i)
            6'd0:  v = 32'sd843314857;
            6'd1:  v = 32'sd497837829;
            6'd2:  v = 32'sd263043837;
            6'd3:  v = 32'sd133525159;
            6'd4:  v = 32'sd67021687;
            6'd5:  v = 32'sd33543516;
            6'd6:  v = 32'sd16775851;
            6'd7:  v = 32'sd8388437;
            6'd8:  v = 32'sd4194283;
            6'd9:  v = 32'sd2097149;
            6'd10: v = 32'sd1048576;
            default: begin
                if (i <= 6'd30) v = 32'sd1 <<< (6'd30 - i);
                else v = 32'sd0;
            end
        endcase
        return v;
    endfunction

    // coefficient of a polynomial term, vertical or sideways path
    function automatic logic signed [32:0] poly_coef(input logic side, input logic [2:0] op);
        longint c;
        case (op)
            OP_P3:   c = side ? -CQ_3  : CQ_1;
            OP_P2:   c = side ?  CQ_9  : -CQ_3;
            OP_P1:   c = side ?  CQ_27 : -CQ_9;
            OP_V2:   c = side ? -CQ_9  : CQ_3;
            OP_V1:   c = side ?  CQ_18 : -CQ_6;
            OP_A1:   c = side ? -CQ_18 : CQ_6;
            default: c = 0;
        endcase
        return c[32:0];
    endfunction

endpackage

// ===== design/tsg_mul.sv =====
// tsg_mul: the shared signed multiplier with registered product and
// round-half-up rescale to FRAC or CORDIC_Q fraction bits.
// Depends on tsg_pkg.
module tsg_mul (
    input  logic               aclk,
    input  logic signed [32:0] op_a,
    input  logic signed [32:0] op_b,
    input  logic               q30_sel,
    output logic signed [65:0] prod,
    output logic signed [31:0] res
);

    logic signed [65:0] prod_reg;
    logic               q30_reg;
    logic signed [65:0] rnd;

    always_ff @(posedge aclk) begin
        prod_reg <= op_a * op_b;
        q30_reg  <= q30_sel;
    end

    always_comb begin
        if (q30_reg) rnd = prod_reg + (66'sd1 <<< (tsg_pkg::CORDIC_Q - 1));
        else rnd = prod_reg + (66'sd1 <<< (tsg_pkg::FRAC - 1));
    end

    assign res  = q30_reg ? rnd[tsg_pkg::CORDIC_Q+31:tsg_pkg::CORDIC_Q]
                          : rnd[tsg_pkg::FRAC+31:tsg_pkg::FRAC];
    assign prod = prod_reg;

endmodule

// ===== design/tsg_angle.sv =====
// tsg_angle: reduces w*t modulo 2*pi by shift and subtract, folds the angle
// and runs CORDIC rotation one step a cycle to give cos and sin in Q30.
// Depends on tsg_pkg.
module tsg_angle #(
    parameter int CORDIC_STEPS = 16
) (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               start,
    input  logic signed [63:0] prod,
    output logic               done,
    output logic signed [33:0] cos_q30,
    output logic signed [33:0] sin_q30
);

    localparam int IW = (CORDIC_STEPS > 1) ? $clog2(CORDIC_STEPS) : 1;
    localparam int DEN_N = (CORDIC_STEPS < 24) ? CORDIC_STEPS : 0;
    localparam longint DEN = longint'(3) <<< (2 * DEN_N);
    localparam longint KQ = (CORDIC_STEPS < 24)
                          ? tsg_pkg::KINF_Q30 + (tsg_pkg::KINF_Q30 * 2 + DEN / 2) / DEN
                          : tsg_pkg::KINF_Q30;
    localparam logic signed [35:0] TP30_Z = 36'(tsg_pkg::TP30);
    localparam logic signed [35:0] PI30_Z = 36'(tsg_pkg::PI30);
    localparam logic signed [35:0] HP30_Z = 36'(tsg_pkg::HP30);

    typedef enum logic [2:0] {
        A_IDLE, A_REDUCE, A_ROUND, A_WRAP, A_HALF, A_ROTATE, A_FINISH
    } ang_state_t;

    ang_state_t         state_reg;
    logic [63:0]        mag_reg;
    logic               sgn_reg;
    logic [4:0]         k_reg;
    logic signed [35:0] z_reg;
    logic signed [33:0] x_reg, y_reg;
    logic               flip_reg;
    logic [IW-1:0]      i_reg;
    logic signed [33:0] cos_reg, sin_reg;
    logic               done_reg;

    logic [63:0]        tp_shift;
    logic signed [35:0] rem_s;
    logic signed [35:0] ang;
    logic signed [33:0] dx, dy;

    always_comb begin
        tp_shift = 64'(tsg_pkg::TP_RED) << k_reg;
        rem_s    = sgn_reg ? -$signed(36'(mag_reg)) : $signed(36'(mag_reg));
        ang      = 36'(tsg_pkg::atan_q30(6'(i_reg)));
        dx       = y_reg >>> i_reg;
        dy       = x_reg >>> i_reg;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= A_IDLE;
            done_reg  <= 1'b0;
        end else begin
            done_reg <= 1'b0;
            unique case (state_reg)
                A_IDLE: begin
                    if (start) begin
                        sgn_reg   <= prod[63];
                        mag_reg   <= prod[63] ? 64'(-prod) : 64'(prod);
                        k_reg     <= 5'(tsg_pkg::RED_TOP);
                        state_reg <= A_REDUCE;
                    end
                end
                A_REDUCE: begin
                    if (mag_reg >= tp_shift) mag_reg <= mag_reg - tp_shift;
                    if (k_reg == 5'd0) state_reg <= A_ROUND;
                    else k_reg <= k_reg - 5'd1;
                end
                A_ROUND: begin
                    z_reg     <= (rem_s + (36'sd1 <<< (tsg_pkg::Z_SH - 1))) >>> tsg_pkg::Z_SH;
                    state_reg <= A_WRAP;
                end
                A_WRAP: begin
                    if (z_reg > PI30_Z) z_reg <= z_reg - TP30_Z;
                    else if (z_reg < -PI30_Z) z_reg <= z_reg + TP30_Z;
                    state_reg <= A_HALF;
                end
                A_HALF: begin
                    // shift by pi into the converging range, flip signs later
                    if (z_reg > HP30_Z) begin
                        z_reg    <= z_reg - PI30_Z;
                        flip_reg <= 1'b1;
                    end else if (z_reg < -HP30_Z) begin
                        z_reg    <= z_reg + PI30_Z;
                        flip_reg <= 1'b1;
                    end else begin
                        flip_reg <= 1'b0;
                    end
                    x_reg     <= 34'(KQ);
                    y_reg     <= 34'sd0;
                    i_reg     <= '0;
                    state_reg <= A_ROTATE;
                end
                A_ROTATE: begin
                    if (z_reg >= 0) begin
                        x_reg <= x_reg - dx;
                        y_reg <= y_reg + dy;
                        z_reg <= z_reg - ang;
                    end else begin
                        x_reg <= x_reg + dx;
                        y_reg <= y_reg - dy;
                        z_reg <= z_reg + ang;
                    end
                    if (i_reg == IW'(CORDIC_STEPS - 1)) state_reg <= A_FINISH;
                    else i_reg <= i_reg + 1'b1;
                end
                A_FINISH: begin
                    cos_reg   <= flip_reg ? -x_reg : x_reg;
                    sin_reg   <= flip_reg ? -y_reg : y_reg;
                    done_reg  <= 1'b1;
                    state_reg <= A_IDLE;
                end
                default: state_reg <= A_IDLE;
            endcase
        end
    end

    assign done    = done_reg;
    assign cos_q30 = cos_reg;
    assign sin_q30 = sin_reg;

endmodule

// ===== design/trajectory_setpoint_generator.sv =====
// Trajectory setpoint generator: one timestamp in, one position, velocity and
// acceleration setpoint out, on a vertical, sideways or circle path.
// A vertical or sideways item runs eight products in turn through one shared
// multiplier, each issued and then taken, between the accept and the handover.
// A circle item runs the 29-step modulo 2*pi reduction and the CORDIC rotation
// in tsg_angle between its first product, w*t, and the six products that follow.
// A hold item goes from the accept straight to the handover. The block takes
// one item at a time; a finished result waits in the output register while
// the next item is computed.
module trajectory_setpoint_generator #(
    parameter int CORDIC_STEPS = 16
) (
    input  logic         aclk,
    input  logic         aresetn,
    input  logic         s_tvalid,
    output logic         s_tready,
    input  logic [31:0]  s_tdata,    // [31:0] now_time
    input  logic [1:0]   s_tuser,    // [1:0] mode
    output logic         m_tvalid,
    input  logic         m_tready,
    // [31:0] pos_x, pos_y, pos_z, vel_x, vel_y, vel_z, acc_x, acc_y, [287:256] acc_z
    output logic [287:0] m_tdata,
    input  logic         cfg_valid,
    output logic         cfg_ready,
    input  logic [7:0]   cfg_index,
    input  logic [31:0]  cfg_data
);

    typedef enum logic [2:0] {ST_IDLE, ST_ISSUE, ST_TAKE, ST_ANGLE, ST_DONE} state_t;

    state_t             state_reg;
    logic [1:0]         mode_reg;
    logic [2:0]         op_reg;
    logic [30:0]        t_reg;
    logic signed [31:0] t2_reg, t3_reg;
    logic signed [31:0] work_reg [9];
    logic [31:0]        last_reg [9];
    logic [31:0]        out_reg  [9];
    logic               m_valid_reg;
    logic               start_seen_reg;
    logic [31:0]        start_time_reg;
    logic [30:0]        radius_reg;
    logic signed [31:0] rate_reg;
    logic [30:0]        limit_reg;
    logic signed [31:0] home_x_reg, home_y_reg, home_z_reg;

    logic [31:0]        start_pick, elapsed;
    logic [30:0]        t_clamp;
    logic signed [31:0] work_init [9];
    logic signed [32:0] mul_a, mul_b;
    logic               mul_q30;
    logic signed [65:0] mul_prod;
    logic signed [31:0] mul_res;
    logic               ang_start, ang_done;
    logic signed [33:0] ang_cos, ang_sin;
    logic signed [32:0] t_op, w_op;
    logic               s_fire, side;

    assign s_tready  = (state_reg == ST_IDLE);
    assign s_fire    = s_tvalid && s_tready;
    assign cfg_ready = 1'b1;
    assign m_tvalid  = m_valid_reg;
    assign side      = (mode_reg == tsg_pkg::MODE_SIDEWAYS);

    always_comb begin
        start_pick = start_seen_reg ? start_time_reg : s_tdata;
        elapsed    = s_tdata - start_pick;
        t_clamp    = (elapsed >= {1'b0, limit_reg}) ? limit_reg : elapsed[30:0];
        t_op       = $signed({2'b00, t_reg});
        w_op       = $signed({rate_reg[31], rate_reg});
    end

    // starting values of the accumulators for the accepted path
    always_comb begin
        for (int j = 0; j < 9; j++) work_init[j] = '0;
        if (s_tuser == tsg_pkg::MODE_VERTICAL) begin
            work_init[0] = home_x_reg;
            work_init[1] = home_y_reg;
            work_init[2] = home_z_reg;
            work_init[5] = 32'(-tsg_pkg::CQ_9);
            work_init[8] = 32'(-tsg_pkg::CQ_6);
        end else if (s_tuser == tsg_pkg::MODE_SIDEWAYS) begin
            work_init[4] = 32'(tsg_pkg::CQ_27);
            work_init[7] = 32'(tsg_pkg::CQ_18);
        end
    end

    // operand selection for the shared multiplier
    always_comb begin
        mul_a   = t_op;
        mul_b   = t_op;
        mul_q30 = 1'b0;
        if (mode_reg == tsg_pkg::MODE_CIRCLE) begin
            case (op_reg)
                tsg_pkg::OP_WT: begin
                    mul_a = w_op;
                    mul_b = t_op;
                end
                tsg_pkg::OP_RC: begin
                    mul_a   = $signed({2'b00, radius_reg});
                    mul_b   = ang_cos[32:0];
                    mul_q30 = 1'b1;
                end
                tsg_pkg::OP_RS: begin
                    mul_a   = $signed({2'b00, radius_reg});
                    mul_b   = ang_sin[32:0];
                    mul_q30 = 1'b1;
                end
                tsg_pkg::OP_VX: begin
                    mul_a = w_op;
                    mul_b = {work_reg[1][31], work_reg[1]};
                end
                tsg_pkg::OP_VY: begin
                    mul_a = w_op;
                    mul_b = -{work_reg[0][31], work_reg[0]};
                end
                tsg_pkg::OP_AX: begin
                    mul_a = w_op;
                    mul_b = {work_reg[4][31], work_reg[4]};
                end
                default: begin
                    mul_a = w_op;
                    mul_b = -{work_reg[3][31], work_reg[3]};
                end
            endcase
        end else begin
            case (op_reg)
                tsg_pkg::OP_T2: begin
                    mul_a = t_op;
                    mul_b = t_op;
                end
                tsg_pkg::OP_T3: begin
                    mul_a = {t2_reg[31], t2_reg};
                    mul_b = t_op;
                end
                tsg_pkg::OP_P3: begin
                    mul_a = tsg_pkg::poly_coef(side, op_reg);
                    mul_b = {t3_reg[31], t3_reg};
                end
                tsg_pkg::OP_P2, tsg_pkg::OP_V2: begin
                    mul_a = tsg_pkg::poly_coef(side, op_reg);
                    mul_b = {t2_reg[31], t2_reg};
                end
                default: begin
                    mul_a = tsg_pkg::poly_coef(side, op_reg);
                    mul_b = t_op;
                end
            endcase
        end
    end

    assign ang_start = (state_reg == ST_TAKE) && (mode_reg == tsg_pkg::MODE_CIRCLE)
                     && (op_reg == tsg_pkg::OP_WT);

    tsg_mul u_mul (
        .aclk    (aclk),
        .op_a    (mul_a),
        .op_b    (mul_b),
        .q30_sel (mul_q30),
        .prod    (mul_prod),
        .res     (mul_res)
    );

    tsg_angle #(.CORDIC_STEPS(CORDIC_STEPS)) u_angle (
        .aclk    (aclk),
        .aresetn (aresetn),
        .start   (ang_start),
        .prod    (mul_prod[63:0]),
        .done    (ang_done),
        .cos_q30 (ang_cos),
        .sin_q30 (ang_sin)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg      <= ST_IDLE;
            m_valid_reg    <= 1'b0;
            start_seen_reg <= 1'b0;
            start_time_reg <= '0;
            radius_reg     <= 31'd65536;
            rate_reg       <= 32'sd131072;
            limit_reg      <= 31'd196608;
            home_x_reg     <= '0;
            home_y_reg     <= '0;
            home_z_reg     <= '0;
            for (int j = 0; j < 9; j++) last_reg[j] <= '0;
        end else begin
            if (m_valid_reg && m_tready && (state_reg != ST_DONE)) m_valid_reg <= 1'b0;

            if (cfg_valid) begin
                unique case (cfg_index)
                    tsg_pkg::REG_RADIUS:       radius_reg <= cfg_data[30:0];
                    tsg_pkg::REG_ANGULAR_RATE: rate_reg   <= $signed(cfg_data);
                    tsg_pkg::REG_TIME_LIMIT:   limit_reg  <= cfg_data[30:0];
                    tsg_pkg::REG_HOME_X:       home_x_reg <= $signed(cfg_data);
                    tsg_pkg::REG_HOME_Y:       home_y_reg <= $signed(cfg_data);
                    tsg_pkg::REG_HOME_Z:       home_z_reg <= $signed(cfg_data);
                    default: ;
                endcase
            end

            unique case (state_reg)
                ST_IDLE: begin
                    if (s_fire) begin
                        start_seen_reg <= 1'b1;
                        start_time_reg <= start_pick;
                        mode_reg       <= s_tuser;
                        t_reg          <= t_clamp;
                        op_reg         <= '0;
                        for (int j = 0; j < 9; j++) work_reg[j] <= work_init[j];
                        state_reg <= (s_tuser == tsg_pkg::MODE_HOLD) ? ST_DONE : ST_ISSUE;
                    end
                end
                ST_ISSUE: state_reg <= ST_TAKE;
                ST_TAKE: begin
                    op_reg <= op_reg + 3'd1;
                    if ((mode_reg == tsg_pkg::MODE_CIRCLE) && (op_reg == tsg_pkg::OP_WT))
                        state_reg <= ST_ANGLE;
                    else if (op_reg == ((mode_reg == tsg_pkg::MODE_CIRCLE) ? tsg_pkg::OP_AY
                                                                           : tsg_pkg::OP_A1))
                        state_reg <= ST_DONE;
                    else
                        state_reg <= ST_ISSUE;
                    if (mode_reg == tsg_pkg::MODE_CIRCLE) begin
                        case (op_reg)
                            tsg_pkg::OP_WT: ;
                            tsg_pkg::OP_RC: work_reg[0] <= mul_res;
                            tsg_pkg::OP_RS: work_reg[1] <= -mul_res;
                            tsg_pkg::OP_VX: work_reg[3] <= mul_res;
                            tsg_pkg::OP_VY: work_reg[4] <= mul_res;
                            tsg_pkg::OP_AX: work_reg[6] <= mul_res;
                            default: work_reg[7] <= mul_res;
                        endcase
                    end else begin
                        case (op_reg)
                            tsg_pkg::OP_T2: t2_reg <= mul_res;
                            tsg_pkg::OP_T3: t3_reg <= mul_res;
                            tsg_pkg::OP_P3, tsg_pkg::OP_P2, tsg_pkg::OP_P1: begin
                                if (side) work_reg[1] <= work_reg[1] + mul_res;
                                else work_reg[2] <= work_reg[2] + mul_res;
                            end
                            tsg_pkg::OP_V2, tsg_pkg::OP_V1: begin
                                if (side) work_reg[4] <= work_reg[4] + mul_res;
                                else work_reg[5] <= work_reg[5] + mul_res;
                            end
                            default: begin
                                if (side) work_reg[7] <= work_reg[7] + mul_res;
                                else work_reg[8] <= work_reg[8] + mul_res;
                            end
                        endcase
                    end
                end
                ST_ANGLE: begin
                    if (ang_done) state_reg <= ST_ISSUE;
                end
                ST_DONE: begin
                    // hand over once the output register is free
                    if (!m_valid_reg || m_tready) begin
                        for (int j = 0; j < 9; j++) begin
                            if (mode_reg == tsg_pkg::MODE_HOLD) begin
                                out_reg[j] <= last_reg[j];
                            end else begin
                                out_reg[j]  <= work_reg[j];
                                last_reg[j] <= work_reg[j];
                            end
                        end
                        m_valid_reg <= 1'b1;
                        state_reg   <= ST_IDLE;
                    end
                end
                default: state_reg <= ST_IDLE;
            endcase
        end
    end

    assign m_tdata = {out_reg[8], out_reg[7], out_reg[6], out_reg[5], out_reg[4],
                      out_reg[3], out_reg[2], out_reg[1], out_reg[0]};

endmodule
